// File: hw/rtl/websocket_frame_deframer_macros.svh
// Assertion macros shared by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

    // Configuration register indexes.
    localparam logic CFG_MAX_PAYLOAD  = 1'b0;
    localparam logic CFG_REQUIRE_MASK = 1'b1;

    // Configuration reset values.
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd33554432;

    // Frame opcodes.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Header length codes and limits.
    localparam logic [6:0]  LEN_EXT16    = 7'd126;
    localparam logic [6:0]  LEN_EXT64    = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

    // Kinds of result items.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_PING   = 2'd2;
    localparam logic [1:0] KIND_PONG   = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RESERVED  = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_UNMASKED  = 3'd3;
    localparam logic [2:0] ST_BAD_CTRL  = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;
    localparam logic [2:0] ST_FRAG      = 3'd6;
    localparam logic [2:0] ST_CLOSE     = 3'd7;

    // One result item as it travels from the parser to the output buffer.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [1:0] frame_kind;
        logic [1:0] message_opcode;
        logic       message_end;
        logic       control_end;
        logic [2:0] status;
    } t_result;

endpackage

// File: hw/rtl/wsd_parser.sv
// Input register, frame parsing state and per-byte result logic.
module wsd_parser import wsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_push,
    output t_result     o_result
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_DATA
    } t_phase;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       fire;

    // Configuration.
    logic [31:0] r_max_payload;
    logic        r_require_mask;

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [31:0] r_mask_key, n_mask_key;
    logic [1:0]  r_mask_idx, n_mask_idx;
    logic        r_frag_active, n_frag_active;
    logic [1:0]  r_frag_op, n_frag_op;
    logic [2:0]  r_latched, n_latched;

    // Working signals of the byte logic.
    t_result     res;
    logic        hdr_done;
    logic [63:0] hdr_len;
    logic        hdr_masked;
    logic [2:0]  hdr_status;
    logic        frame_end;
    logic [7:0]  key_byte;
    logic [7:0]  b;

    // The byte in the input register moves on when the output buffer has room.
    assign fire    = r_in_valid && i_out_ready;
    assign o_stall = r_in_valid && !i_out_ready;
    assign o_push  = fire;
    assign o_result = res;
    assign b       = r_in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload  <= MAX_PAYLOAD_RESET;
            r_require_mask <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_PAYLOAD:  r_max_payload  <= i_cfg_data;
                CFG_REQUIRE_MASK: r_require_mask <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Mask key byte for the current payload position, most significant first.
    always_comb begin
        unique case (r_mask_idx)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    // Header checks, in priority order, once the payload length is known.
    always_comb begin
        priority if (hdr_len > {32'd0, r_max_payload}) begin
            hdr_status = ST_TOO_LARGE;
        end else if (r_require_mask && !hdr_masked) begin
            hdr_status = ST_UNMASKED;
        end else if (r_opcode[3] && (!r_fin || hdr_len > CTRL_MAX_LEN)) begin
            hdr_status = ST_BAD_CTRL;
        end else if (r_opcode == OP_CLOSE) begin
            hdr_status = ST_CLOSE;
        end else if (r_opcode > OP_PONG || (r_opcode > OP_BINARY && !r_opcode[3])) begin
            hdr_status = ST_UNKNOWN;
        end else if ((r_opcode == OP_TEXT || r_opcode == OP_BINARY) && r_frag_active) begin
            hdr_status = ST_FRAG;
        end else if (r_opcode == OP_CONT && !r_frag_active) begin
            hdr_status = ST_FRAG;
        end else begin
            hdr_status = ST_OK;
        end
    end

    // Next state and result for the byte in the input register.
    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_fin         = r_fin;
        n_opcode      = r_opcode;
        n_masked      = r_masked;
        n_len         = r_len;
        n_mask_key    = r_mask_key;
        n_mask_idx    = r_mask_idx;
        n_frag_active = r_frag_active;
        n_frag_op     = r_frag_op;
        n_latched     = r_latched;
        res           = '0;
        hdr_done      = 1'b0;
        hdr_len       = {r_len[55:0], b};
        hdr_masked    = r_masked;
        frame_end     = 1'b0;

        if (r_latched != ST_OK) begin
            // After an error or a close, every byte only repeats the status.
            res.status = r_latched;
        end else begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_fin    = b[7];
                    n_opcode = b[3:0];
                    if (b[6:4] != 3'd0) begin
                        n_latched  = ST_RESERVED;
                        res.status = ST_RESERVED;
                    end else begin
                        n_phase = PH_HDR1;
                    end
                end
                PH_HDR1: begin
                    n_masked   = b[7];
                    hdr_masked = b[7];
                    n_cnt      = 3'd0;
                    n_len      = '0;
                    hdr_len    = {57'd0, b[6:0]};
                    if (b[6:0] == LEN_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (b[6:0] == LEN_EXT64) begin
                        n_phase = PH_EXT64;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    n_len = hdr_len;
                    n_cnt = r_cnt + 3'd1;
                    if ((r_phase == PH_EXT16 && n_cnt == 3'd2) ||
                        (r_phase == PH_EXT64 && n_cnt == 3'd0)) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], b};
                    n_cnt      = r_cnt + 3'd1;
                    if (n_cnt[2]) begin
                        n_cnt      = 3'd0;
                        n_mask_idx = 2'd0;
                        if (r_len == 64'd0) begin
                            frame_end = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_mask_idx        = r_mask_idx + 2'd1;
                    res.payload_byte  = r_masked ? (b ^ key_byte) : b;
                    res.payload_valid = 1'b1;
                    if (r_opcode == OP_PING) begin
                        res.frame_kind = KIND_PING;
                    end else if (r_opcode == OP_PONG) begin
                        res.frame_kind = KIND_PONG;
                    end else begin
                        res.frame_kind     = KIND_DATA;
                        res.message_opcode = r_frag_op;
                    end
                    if (r_len != 64'd0) begin
                        n_len = r_len - 64'd1;
                    end
                    if (r_len <= 64'd1) begin
                        frame_end = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // Header complete: check it, then open the payload or finish.
            if (hdr_done) begin
                if (hdr_status != ST_OK) begin
                    n_latched  = hdr_status;
                    res.status = hdr_status;
                end else begin
                    if (r_opcode == OP_TEXT || r_opcode == OP_BINARY) begin
                        n_frag_active = 1'b1;
                        n_frag_op     = r_opcode[1:0];
                    end
                    n_len      = hdr_len;
                    n_mask_idx = 2'd0;
                    n_cnt      = 3'd0;
                    if (hdr_masked) begin
                        n_phase = PH_MASK;
                    end else if (hdr_len == 64'd0) begin
                        frame_end = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end

            // End of a frame: mark control frames and final data fragments.
            if (frame_end) begin
                if (r_opcode == OP_PING || r_opcode == OP_PONG) begin
                    res.control_end = 1'b1;
                end else if (r_fin) begin
                    res.message_end    = 1'b1;
                    res.message_opcode = n_frag_op;
                    n_frag_active      = 1'b0;
                    n_frag_op          = 2'd0;
                end
                n_phase = PH_HDR0;
            end
        end
    end

    // Parser state advances once per transfer out of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_cnt         <= 3'd0;
            r_fin         <= 1'b0;
            r_opcode      <= OP_CONT;
            r_masked      <= 1'b0;
            r_len         <= '0;
            r_mask_key    <= '0;
            r_mask_idx    <= 2'd0;
            r_frag_active <= 1'b0;
            r_frag_op     <= 2'd0;
            r_latched     <= ST_OK;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_fin         <= n_fin;
            r_opcode      <= n_opcode;
            r_masked      <= n_masked;
            r_len         <= n_len;
            r_mask_key    <= n_mask_key;
            r_mask_idx    <= n_mask_idx;
            r_frag_active <= n_frag_active;
            r_frag_op     <= n_frag_op;
            r_latched     <= n_latched;
        end
    end

endmodule

// File: hw/rtl/wsd_out_buf.sv
// Two-entry result buffer between the parser and the output channel.
module wsd_out_buf import wsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result    r_ent [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    // Room is judged on the registered count, so ready never waits on i_stall.
    assign o_ready  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign pop      = o_valid && !i_stall;
    assign o_result = r_ent[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_result;
        end
    end

endmodule

// File: hw/rtl/websocket_frame_deframer.sv
// WebSocket receive deframer (server side). It takes one received byte per
// clock unless o_stall holds it, and gives one result item per byte: a
// header marker, or an unmasked payload byte tagged as data, ping or pong.
// A byte is registered in the input register, and the parser turns it into
// a result that is written into a two-entry output buffer, from which it is
// offered on the output. The sustained rate is one byte per cycle when the
// output side takes results as they come. A stall on the output holds the
// input only once both buffer entries are full and a byte waits in the input
// register. Any header error or a close frame latches its status; every later
// byte then returns only that status until reset. Configuration writes are
// always taken and must be made while no byte is in flight.
module websocket_frame_deframer import wsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received bytes.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Result items.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic [1:0]  o_frame_kind,
    output logic [1:0]  o_message_opcode,
    output logic        o_message_end,
    output logic        o_control_end,
    output logic [2:0]  o_status
);

    logic    out_ready;
    logic    push;
    t_result parsed;
    t_result head;

    assign o_cfg_ready = 1'b1;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (out_ready),
        .o_push      (push),
        .o_result    (parsed)
    );

    wsd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (parsed),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (head)
    );

    // Result fields onto their own ports.
    assign o_payload_byte   = head.payload_byte;
    assign o_payload_valid  = head.payload_valid;
    assign o_frame_kind     = head.frame_kind;
    assign o_message_opcode = head.message_opcode;
    assign o_message_end    = head.message_end;
    assign o_control_end    = head.control_end;
    assign o_status         = head.status;

endmodule

// File: hw/rtl/wsd_checker.sv
// Port-level checks of the deframer and their binding to the top level.
`include "websocket_frame_deframer_macros.svh"

module wsd_checker import wsd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_payload_byte,
    input logic        o_payload_valid,
    input logic [1:0]  o_frame_kind,
    input logic [1:0]  o_message_opcode,
    input logic        o_message_end,
    input logic        o_control_end,
    input logic [2:0]  o_status
);

    // A result held by a stall keeps its status and payload.
    `WSD_ASSERT_NEXT(a_held_result, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_payload_byte), "stalled result changed")

    // An error or close item carries nothing but its status.
    `WSD_ASSERT_NOW(a_status_only, o_valid && o_status != ST_OK, !o_payload_valid && o_frame_kind == KIND_HEADER && !o_message_end && !o_control_end, "status item carries data")

    // Payload bytes and only payload bytes have a nonzero kind.
    `WSD_ASSERT_NOW(a_kind_matches, o_valid, o_payload_valid == (o_frame_kind != KIND_HEADER), "kind and payload flag disagree")

    // A message type shows only on data bytes or at a message end.
    `WSD_ASSERT_NOW(a_msg_opcode, o_valid && o_message_opcode != 2'd0, o_frame_kind == KIND_DATA || o_message_end, "message type outside a data message")

    // A frame cannot end both a data message and a control frame.
    `WSD_ASSERT_NOW(a_one_end, o_valid, !(o_message_end && o_control_end), "both end marks set")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

// File: sim/deframe_tracker_pkg.sv
// Bit-exact tracker of the WebSocket deframer and its queue of expected result items.
package deframe_tracker_pkg;
    import wsd_pkg::*;

    // Parser position within a frame.
    typedef enum logic [2:0] {
        AT_BYTE0,
        AT_BYTE1,
        AT_LEN16,
        AT_LEN64,
        AT_KEY,
        AT_PAYLOAD,
        AT_HALT
    } parse_step_e;

    class deframe_tracker;
        // Register copies.
        logic [31:0] max_len;
        logic        need_mask;

        // Parser state.
        parse_step_e step;
        logic [2:0]  field_cnt;
        logic        fin;
        logic [3:0]  op;
        logic        masked;
        logic [63:0] length;
        logic [63:0] remaining;
        logic [31:0] key;
        logic [1:0]  key_pos;
        logic        msg_open;
        logic [3:0]  msg_op;
        logic [2:0]  halted_status;

        // Result item under construction and the items still to arrive.
        t_result     now;
        t_result     deframed_items[$];
        int          failures;

        function new();
            max_len       = MAX_PAYLOAD_RESET;
            need_mask     = 1'b1;
            step          = AT_BYTE0;
            field_cnt     = '0;
            fin           = 1'b0;
            op            = OP_CONT;
            masked        = 1'b0;
            length        = '0;
            remaining     = '0;
            key           = '0;
            key_pos       = '0;
            msg_open      = 1'b0;
            msg_op        = OP_CONT;
            halted_status = ST_OK;
            failures      = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == CFG_MAX_PAYLOAD) begin
                max_len = val;
            end else begin
                need_mask = val[0];
            end
        endfunction

        // Marks the end of a frame; a final data fragment closes the message.
        function void end_frame();
            if (op == OP_PING || op == OP_PONG) begin
                now.control_end = 1'b1;
            end else if (fin) begin
                now.message_end    = 1'b1;
                now.message_opcode = msg_op[1:0];
                msg_open           = 1'b0;
                msg_op             = OP_CONT;
            end
            step = AT_BYTE0;
        endfunction

        // Header checks in priority order.
        function logic [2:0] header_status();
            if (length > {32'd0, max_len}) return ST_TOO_LARGE;
            if (need_mask && !masked) return ST_UNMASKED;
            if (op >= OP_CLOSE && (!fin || length > CTRL_MAX_LEN)) return ST_BAD_CTRL;
            if (op == OP_CLOSE) return ST_CLOSE;
            if (op > OP_PONG || (op > OP_BINARY && op < OP_CLOSE)) return ST_UNKNOWN;
            if ((op == OP_TEXT || op == OP_BINARY) && msg_open) return ST_FRAG;
            if (op == OP_CONT && !msg_open) return ST_FRAG;
            return ST_OK;
        endfunction

        function void halt(logic [2:0] s);
            halted_status = s;
            step          = AT_HALT;
            now.status    = s;
        endfunction

        // Runs once the payload length is known.
        function void header_done();
            logic [2:0] s;
            s = header_status();
            if (s != ST_OK) begin
                halt(s);
                return;
            end
            if (op == OP_TEXT || op == OP_BINARY) begin
                msg_open = 1'b1;
                msg_op   = op;
            end
            remaining = length;
            key_pos   = '0;
            field_cnt = '0;
            if (masked) begin
                step = AT_KEY;
            end else if (length == 0) begin
                end_frame();
            end else begin
                step = AT_PAYLOAD;
            end
        endfunction

        // Works out the result item caused by one received byte.
        function t_result deframe_byte(logic [7:0] b);
            logic [7:0] kb;
            now = '0;
            if (halted_status != ST_OK) begin
                now.status = halted_status;
                return now;
            end
            case (step)
                AT_BYTE0: begin
                    fin = b[7];
                    op  = b[3:0];
                    if (b[6:4] != 3'd0) begin
                        halt(ST_RESERVED);
                    end else begin
                        step = AT_BYTE1;
                    end
                end
                AT_BYTE1: begin
                    masked    = b[7];
                    field_cnt = '0;
                    length    = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        step = AT_LEN16;
                    end else if (b[6:0] == LEN_EXT64) begin
                        step = AT_LEN64;
                    end else begin
                        length = 64'(b[6:0]);
                        header_done();
                    end
                end
                AT_LEN16, AT_LEN64: begin
                    length    = {length[55:0], b};
                    field_cnt = field_cnt + 3'd1;
                    if ((step == AT_LEN16 && field_cnt == 3'd2) ||
                        (step == AT_LEN64 && field_cnt == 3'd0)) begin
                        header_done();
                    end
                end
                AT_KEY: begin
                    key       = {key[23:0], b};
                    field_cnt = field_cnt + 3'd1;
                    if (field_cnt >= 3'd4) begin
                        field_cnt = '0;
                        key_pos   = '0;
                        if (length == 0) begin
                            end_frame();
                        end else begin
                            step = AT_PAYLOAD;
                        end
                    end
                end
                AT_PAYLOAD: begin
                    // Key bytes are applied most significant first.
                    kb = masked ? 8'(key >> (24 - 8 * int'(key_pos))) : 8'h00;
                    key_pos           = key_pos + 2'd1;
                    now.payload_byte  = b ^ kb;
                    now.payload_valid = 1'b1;
                    if (op == OP_PING) begin
                        now.frame_kind = KIND_PING;
                    end else if (op == OP_PONG) begin
                        now.frame_kind = KIND_PONG;
                    end else begin
                        now.frame_kind     = KIND_DATA;
                        now.message_opcode = msg_op[1:0];
                    end
                    if (remaining != 0) remaining--;
                    if (remaining == 0) end_frame();
                end
                default: begin
                    step = AT_BYTE0;
                end
            endcase
            return now;
        endfunction

        // Called for every byte transfer on the input side.
        function void take_byte(logic [7:0] b);
            t_result item;
            item = deframe_byte(b);
            deframed_items = {deframed_items, item};
        endfunction

        function string item_text(t_result r);
            return $sformatf("byte=%h pv=%b kind=%0d msg_op=%0d msg_end=%b ctl_end=%b status=%0d",
                             r.payload_byte, r.payload_valid, r.frame_kind, r.message_opcode,
                             r.message_end, r.control_end, r.status);
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10) $display("MISMATCH: %s", what);
        endfunction

        // Called for every result transfer on the output side.
        function void check_item(t_result got);
            t_result want;
            if (deframed_items.size() == 0) begin
                note_failure({"result with nothing pending: ", item_text(got)});
                return;
            end
            want = deframed_items.pop_front();
            if (got.payload_byte !== want.payload_byte ||
                got.payload_valid !== want.payload_valid ||
                got.frame_kind !== want.frame_kind ||
                got.message_opcode !== want.message_opcode ||
                got.message_end !== want.message_end ||
                got.control_end !== want.control_end ||
                got.status !== want.status) begin
                note_failure({"expected ", item_text(want), " got ", item_text(got)});
            end
        endfunction

        function int pending();
            return deframed_items.size();
        endfunction

        function void close_out();
            if (deframed_items.size() != 0) begin
                note_failure($sformatf("%0d results never arrived", deframed_items.size()));
            end
        endfunction
    endclass

endpackage

// File: sim/testbench.sv
// Random and directed stimulus, output stalls and result checking for the WebSocket deframer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wsd_pkg::*;
    import deframe_tracker_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int BYTE_GOAL   = 1750;
    localparam int TAIL_CYCLES = 8;
    localparam int NOISE_BYTES = 40;

    // How the payload length is encoded in the header.
    localparam int LEN_NATURAL = 0;
    localparam int LEN_FORCE16 = 1;
    localparam int LEN_FORCE64 = 2;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_MAX_PAYLOAD;
    logic [31:0] i_cfg_data  = 32'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_cfg_ready;
    logic        o_valid;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic [1:0]  o_frame_kind;
    logic [1:0]  o_message_opcode;
    logic        o_message_end;
    logic        o_control_end;
    logic [2:0]  o_status;

    deframe_tracker tracker = new();

    // Stimulus bookkeeping.
    logic        valid_held    = 1'b0;
    logic        in_quiet      = 1'b0;
    logic        gen_open      = 1'b0;
    logic [31:0] cur_max       = MAX_PAYLOAD_RESET;
    logic        cur_need_mask = 1'b1;
    int          bytes_sent    = 0;

    // Output stall pattern and watchdog.
    int          stall_left  = 0;
    int          span_left   = 0;
    logic        out_quiet   = 1'b0;
    int          idle_cycles = 0;

    websocket_frame_deframer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_frame_kind     (o_frame_kind),
        .o_message_opcode (o_message_opcode),
        .o_message_end    (o_message_end),
        .o_control_end    (o_control_end),
        .o_status         (o_status)
    );

    always #1 i_clk = ~i_clk;

    // Idle lengths: mostly short, now and then long.
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Result transfers are checked here; the stall pattern alternates busy and quiet spans.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_item(t_result'({o_payload_byte, o_payload_valid, o_frame_kind,
                                          o_message_opcode, o_message_end, o_control_end,
                                          o_status}));
        end
        if (span_left == 0) begin
            span_left = $urandom_range(50, 400);
            out_quiet = ($urandom_range(0, 3) == 0);
        end
        span_left--;
        if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!out_quiet && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One byte transfer, after an optional gap; valid stays high for a back-to-back byte.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (in_quiet || $urandom_range(0, 2) != 0) ? 0 : gap_length();
        if (gap != 0) begin
            if (valid_held) i_valid <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        valid_held = 1'b1;
        bytes_sent++;
        tracker.take_byte(b);
    endtask

    task automatic stop_input();
        if (valid_held) begin
            i_valid <= 1'b0;
            valid_held = 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Holds the sender until every pending result has come out.
    task automatic wait_drained();
        stop_input();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic configure(input logic [31:0] max_len, input logic need_mask);
        logic [31:0] mask_word;
        mask_word = {31'($urandom()), need_mask};
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MAX_PAYLOAD;
        i_cfg_data  <= max_len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_reg(CFG_MAX_PAYLOAD, max_len);
        i_cfg_index <= CFG_REQUIRE_MASK;
        i_cfg_data  <= mask_word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_reg(CFG_REQUIRE_MASK, mask_word);
        i_cfg_valid <= 1'b0;
        cur_max       = max_len;
        cur_need_mask = need_mask;
    endtask

    // Header bytes: first byte, length with its extension, then the mask key.
    task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                               input logic masked, input logic [63:0] length, input int form,
                               input logic [31:0] key);
        send_byte({fin, rsv, op});
        if (form == LEN_FORCE64 || (form == LEN_NATURAL && length > 64'd65535)) begin
            send_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) send_byte(length[8 * i +: 8]);
        end else if (form == LEN_FORCE16 || length > CTRL_MAX_LEN) begin
            send_byte({masked, LEN_EXT16});
            send_byte(length[15:8]);
            send_byte(length[7:0]);
        end else begin
            send_byte({masked, length[6:0]});
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        end
    endtask

    // A well-formed frame; the alternating pattern sends 00, ff, 00, ...
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input logic [63:0] length, input int form,
                              input logic [31:0] key, input logic pattern);
        send_header(fin, 3'd0, op, masked, length, form, key);
        for (int i = 0; i < int'(length); i++) begin
            send_byte(pattern ? {8{i[0]}} : 8'($urandom()));
        end
        if (op == OP_TEXT || op == OP_BINARY) begin
            gen_open = !fin;
        end else if (op == OP_CONT && fin) begin
            gen_open = 1'b0;
        end
    endtask

    // Payload lengths: mostly short, a few reaching into the 16-bit range.
    function automatic logic [63:0] pick_length(input logic [63:0] cap);
        int          r;
        logic [63:0] n;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            n = $urandom_range(0, 8);
        end else if (r < 85) begin
            n = $urandom_range(9, 125);
        end else if (r < 95) begin
            n = $urandom_range(126, 300);
        end else begin
            n = $urandom_range(301, 1000);
        end
        return (n > cap) ? cap : n;
    endfunction

    // A legal frame under the current settings; control frames may interleave a message.
    task automatic random_frame();
        logic [3:0]  op;
        logic        fin;
        logic        masked;
        logic [63:0] cap;
        logic [63:0] length;
        int          form;
        int          r;
        if ($urandom_range(0, 39) == 0) wait_drained();
        in_quiet = ($urandom_range(0, 4) == 0);
        cap = {32'd0, cur_max};
        r = $urandom_range(0, 9);
        if (r < 2) begin
            op  = (r == 0) ? OP_PING : OP_PONG;
            fin = 1'b1;
            if (cap > CTRL_MAX_LEN) cap = CTRL_MAX_LEN;
        end else begin
            op  = gen_open ? OP_CONT : ($urandom_range(0, 1) ? OP_TEXT : OP_BINARY);
            fin = ($urandom_range(0, 2) != 0);
        end
        masked = cur_need_mask || $urandom_range(0, 1);
        length = pick_length(cap);
        r = $urandom_range(0, 9);
        form = (r == 0) ? LEN_FORCE64 : (r == 1) ? LEN_FORCE16 : LEN_NATURAL;
        send_frame(fin, op, masked, length, form, $urandom(), 1'b0);
    endtask

    // One header that latches an error or a close; the status then holds until reset.
    task automatic broken_frame();
        logic [2:0]  err;
        logic [3:0]  op;
        logic [31:0] key;
        int          r;
        err = 3'($urandom_range(ST_RESERVED, ST_CLOSE));
        key = $urandom();
        r   = $urandom_range(0, 9);
        case (err)
            ST_RESERVED: begin
                send_header(1'b1, 3'($urandom_range(1, 7)), OP_TEXT, 1'b1, 64'd5,
                            LEN_NATURAL, key);
            end
            ST_TOO_LARGE: begin
                send_header(1'b1, 3'd0, OP_BINARY, 1'b1, '1, LEN_FORCE64, key);
            end
            ST_UNMASKED: begin
                send_header(1'b1, 3'd0, OP_BINARY, 1'b0, 64'd5, LEN_NATURAL, key);
            end
            ST_BAD_CTRL: begin
                if (r < 5) begin
                    send_header(1'b0, 3'd0, OP_PING, 1'b1, 64'd3, LEN_NATURAL, key);
                end else begin
                    send_header(1'b1, 3'd0, OP_PONG, 1'b1, CTRL_MAX_LEN + 1, LEN_NATURAL, key);
                end
            end
            ST_UNKNOWN: begin
                op = (r < 5) ? OP_BINARY + 4'(1 + r) : OP_PONG + 4'(r - 4);
                send_header(1'b1, 3'd0, op, 1'b1, 64'd2, LEN_NATURAL, key);
            end
            ST_FRAG: begin
                send_header(1'b1, 3'd0, gen_open ? OP_TEXT : OP_CONT, 1'b1, 64'd2,
                            LEN_NATURAL, key);
            end
            default: begin
                send_header(1'b1, 3'd0, OP_CLOSE, 1'b1, 64'd2, LEN_NATURAL, key);
            end
        endcase
    endtask

    // Main sequence.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames: fragments with an interleaved empty ping, an empty
        // non-final continuation, an all-ones key, and empty final frames.
        configure(32'hFFFF_FFFF, 1'b0);
        send_frame(1'b0, OP_TEXT, 1'b0, 64'd2, LEN_NATURAL, 32'd0, 1'b1);
        send_frame(1'b1, OP_PING, 1'b0, 64'd0, LEN_NATURAL, 32'd0, 1'b0);
        send_frame(1'b0, OP_CONT, 1'b0, 64'd0, LEN_NATURAL, 32'd0, 1'b0);
        send_frame(1'b1, OP_PONG, 1'b1, 64'd2, LEN_NATURAL, 32'hFFFF_FFFF, 1'b1);
        send_frame(1'b1, OP_CONT, 1'b1, 64'd1, LEN_FORCE16, 32'd0, 1'b0);
        send_frame(1'b1, OP_BINARY, 1'b0, 64'd0, LEN_NATURAL, 32'd0, 1'b0);

        // Random frames under several settings.
        configure(32'hFFFF_FFFF, 1'b1);
        while (bytes_sent < 600) random_frame();
        configure(32'd0, 1'b0);
        while (bytes_sent < 750) random_frame();
        configure(32'($urandom_range(1, 300)), 1'b0);
        while (bytes_sent < 1200) random_frame();
        configure(MAX_PAYLOAD_RESET, 1'b1);
        while (bytes_sent < BYTE_GOAL) random_frame();

        // Latch a header error or a close, then check that noise only repeats the status.
        configure($urandom_range(0, 1) ? MAX_PAYLOAD_RESET : 32'hFFFF_FFFF, 1'b1);
        in_quiet = 1'b0;
        broken_frame();
        repeat (NOISE_BYTES) send_byte(8'($urandom()));

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        tracker.close_out();
        if (tracker.failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
